// File: hdl/aip_pkg.sv
`timescale 1ns / 1ps

package aip_pkg;

    // Digit limits of the string body
    localparam logic [4:0] MAX_DEC_DIGITS = 5'd20;
    localparam logic [4:0] MAX_HEX_DIGITS = 5'd16;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_LO_X  = 8'h78;
    localparam logic [7:0] CH_UP_X  = 8'h58;

    // Target type register: bit 2 is signedness, bits 1:0 the size
    localparam int          TYPE_SIGNED_BIT = 2;
    localparam logic [2:0]  TYPE_RESET      = 3'd3;
    localparam logic [1:0]  SIZE_8          = 2'd0;
    localparam logic [1:0]  SIZE_16         = 2'd1;
    localparam logic [1:0]  SIZE_32         = 2'd2;
    localparam logic [1:0]  SIZE_64         = 2'd3;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_DEC,
        PH_HEXP,
        PH_HEX
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_SYNTAX,
        ST_RANGE
    } status_t;

    // Parse state of one string
    typedef struct packed {
        phase_t      phase;
        logic [63:0] acc;
        logic [4:0]  digit_count;
        logic        negative;
        logic        overflowed;
        logic        syntax_bad;
    } str_state_t;

    localparam str_state_t STR_CLEAR = '{
        phase:       PH_START,
        acc:         64'd0,
        digit_count: 5'd0,
        negative:    1'b0,
        overflowed:  1'b0,
        syntax_bad:  1'b0
    };

endpackage

// File: hdl/ascii_integer_parser.sv
`timescale 1ns / 1ps

// ASCII integer parser. Takes one character per beat on the slave stream
// (tlast on the final character) and gives one result beat per string: a
// 64-bit value (two's complement for signed types) and a status in tuser
// (0 ok, 1 syntax error, 2 out of range; value is 0 on error). The body is
// 1 to 20 decimal digits or 0x/0X with 1 to 16 uppercase hex digits; signed
// types allow one leading + or -. One character is accepted every cycle
// unless a final character waits on a stalled result stage; the rate is
// set by the per-character step of the accumulator (times ten by shift and
// add, plus the digit), which is combinational. A final character passes
// the input register, the end-of-string register and the output register
// before its result is valid. The user writes the target type on the cfg
// channel only while idle (not enforced by the block); reset value is u64.
module ascii_integer_parser import aip_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: target_type
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    // Character stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [1:0]  m_tuser    // [1:0] status
);

    logic [2:0]  target_type_reg;
    logic        end_valid;
    logic        end_ready;
    str_state_t  end_state;
    status_t     status;

    // Target type register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_type_reg <= TYPE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            target_type_reg <= cfg_data;
        end
    end

    aip_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .char_code   (s_tdata),
        .last_char   (s_tlast),
        .target_type (target_type_reg),
        .end_valid   (end_valid),
        .end_ready   (end_ready),
        .end_state   (end_state)
    );

    aip_result u_result (
        .clk         (clk),
        .rst_n       (rst_n),
        .end_valid   (end_valid),
        .end_ready   (end_ready),
        .end_state   (end_state),
        .target_type (target_type_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .value       (m_tdata),
        .status      (status)
    );

    assign m_tuser = status;

    // An error result carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != ST_OK)) |-> (m_tdata == 64'd0))
        else $error("error result with nonzero value");

    // Status code 3 never appears
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("undefined status code");

    // A finished string held for the result stage is not lost or altered
    assert property (@(posedge clk) disable iff (!rst_n)
        (end_valid && !end_ready) |=> (end_valid && $stable(end_state)))
        else $error("end-of-string register changed while stalled");

    // A u8 ok result never has a value above the 8-bit range
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_OK) && $stable(target_type_reg)
         && (target_type_reg == 3'd0)) |-> (m_tdata[63:8] == 56'd0))
        else $error("u8 result out of range");

endmodule

// File: hdl/aip_scan.sv
`timescale 1ns / 1ps

// Character scanner: input register, running parse state, and the
// end-of-string register that hands a finished string to the result stage.
module aip_scan import aip_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  char_code,
    input  logic        last_char,
    input  logic [2:0]  target_type,
    output logic        end_valid,
    input  logic        end_ready,
    output str_state_t  end_state
);

    logic        in_valid_reg;
    logic [7:0]  char_reg;
    logic        last_reg;
    str_state_t  str_reg;
    str_state_t  str_next;
    logic        end_valid_reg;
    str_state_t  end_state_reg;
    logic        end_free;
    logic        advance;

    logic        is_dec;
    logic        is_hex_alpha;
    logic        is_sign;
    logic [3:0]  hex_val;
    logic [67:0] dec_prod;

    // Pipeline flow
    assign end_free = !end_valid_reg || end_ready;
    assign advance  = in_valid_reg && (!last_reg || end_free);
    assign s_tready = !in_valid_reg || advance;

    // Character classes
    assign is_dec       = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
    assign is_hex_alpha = (char_reg >= CH_UP_A) && (char_reg <= CH_UP_F);
    assign is_sign      = (char_reg == CH_PLUS) || (char_reg == CH_MINUS);
    assign hex_val      = is_hex_alpha ? (char_reg[3:0] + 4'd9) : char_reg[3:0];

    // acc * 10 + digit, kept wide so the carry out shows overflow
    assign dec_prod = ({4'd0, str_reg.acc} << 3) + ({4'd0, str_reg.acc} << 1)
                    + {64'd0, char_reg[3:0]};

    // One character step
    always_comb
    begin
        str_next = str_reg;
        if (!str_reg.syntax_bad)
        begin
            unique case (str_reg.phase)
                PH_START, PH_SIGN:
                begin
                    if (is_sign && (str_reg.phase == PH_START))
                    begin
                        if (!target_type[TYPE_SIGNED_BIT])
                        begin
                            str_next.syntax_bad = 1'b1;
                        end
                        else
                        begin
                            str_next.negative = (char_reg == CH_MINUS);
                            str_next.phase    = PH_SIGN;
                        end
                    end
                    else if (is_dec)
                    begin
                        str_next.acc         = {60'd0, char_reg[3:0]};
                        str_next.digit_count = 5'd1;
                        str_next.phase       = (char_reg == CH_ZERO) ? PH_ZERO : PH_DEC;
                    end
                    else
                    begin
                        str_next.syntax_bad = 1'b1;
                    end
                end
                PH_ZERO, PH_DEC:
                begin
                    if ((str_reg.phase == PH_ZERO)
                        && ((char_reg == CH_LO_X) || (char_reg == CH_UP_X)))
                    begin
                        str_next.digit_count = 5'd0;
                        str_next.acc         = 64'd0;
                        str_next.phase       = PH_HEXP;
                    end
                    else if (!is_dec || (str_reg.digit_count >= MAX_DEC_DIGITS))
                    begin
                        str_next.syntax_bad = 1'b1;
                    end
                    else
                    begin
                        str_next.digit_count = str_reg.digit_count + 5'd1;
                        str_next.overflowed  = str_reg.overflowed || (dec_prod[67:64] != 4'd0);
                        str_next.acc         = dec_prod[63:0];
                        str_next.phase       = PH_DEC;
                    end
                end
                PH_HEXP, PH_HEX:
                begin
                    if (!(is_dec || is_hex_alpha)
                        || (str_reg.digit_count >= MAX_HEX_DIGITS))
                    begin
                        str_next.syntax_bad = 1'b1;
                    end
                    else
                    begin
                        str_next.digit_count = str_reg.digit_count + 5'd1;
                        str_next.acc         = {str_reg.acc[59:0], hex_val};
                        str_next.phase       = PH_HEX;
                    end
                end
                default:
                begin
                    str_next.syntax_bad = 1'b1;
                end
            endcase
        end
    end

    // Input register, parse state and end-of-string register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            last_reg      <= 1'b0;
            str_reg       <= STR_CLEAR;
            end_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
                last_reg     <= last_char;
            end
            if (end_ready)
            begin
                end_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                if (last_reg)
                begin
                    str_reg       <= STR_CLEAR;
                    end_valid_reg <= 1'b1;
                end
                else
                begin
                    str_reg <= str_next;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tready)
        begin
            char_reg <= char_code;
        end
        if (advance && last_reg)
        begin
            end_state_reg <= str_next;
        end
    end

    assign end_valid = end_valid_reg;
    assign end_state = end_state_reg;

endmodule

// File: hdl/aip_result.sv
`timescale 1ns / 1ps

// Range check of a finished string against the target type, and the
// output register of the result stream.
module aip_result import aip_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        end_valid,
    output logic        end_ready,
    input  str_state_t  end_state,
    input  logic [2:0]  target_type,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] value,
    output status_t     status
);

    logic        out_valid_reg;
    logic [63:0] value_reg;
    logic [63:0] value_next;
    status_t     status_reg;
    status_t     status_next;
    logic        body_ok;
    logic        above_umax;
    logic        above_half;
    logic        is_min_mag;
    logic [63:0] acc;

    assign acc       = end_state.acc;
    assign end_ready = !out_valid_reg || m_tready;
    assign body_ok   = (end_state.phase == PH_ZERO) || (end_state.phase == PH_DEC)
                     || (end_state.phase == PH_HEX);

    // Magnitude against the type's bounds; is_min_mag marks exactly 2^(w-1)
    always_comb
    begin
        unique case (target_type[1:0])
            SIZE_8:
            begin
                above_umax = (acc[63:8] != 56'd0);
                above_half = (acc[63:7] != 57'd0);
                is_min_mag = (acc == 64'h80);
            end
            SIZE_16:
            begin
                above_umax = (acc[63:16] != 48'd0);
                above_half = (acc[63:15] != 49'd0);
                is_min_mag = (acc == 64'h8000);
            end
            SIZE_32:
            begin
                above_umax = (acc[63:32] != 32'd0);
                above_half = (acc[63:31] != 33'd0);
                is_min_mag = (acc == 64'h8000_0000);
            end
            SIZE_64:
            begin
                above_umax = 1'b0;
                above_half = acc[63];
                is_min_mag = (acc == 64'h8000_0000_0000_0000);
            end
            default:
            begin
                above_umax = 1'b0;
                above_half = 1'b0;
                is_min_mag = 1'b0;
            end
        endcase
    end

    // Final status and value
    always_comb
    begin
        value_next  = 64'd0;
        status_next = ST_OK;
        priority if (end_state.syntax_bad || !body_ok)
        begin
            status_next = ST_SYNTAX;
        end
        else if (end_state.overflowed)
        begin
            status_next = ST_RANGE;
        end
        else if (!target_type[TYPE_SIGNED_BIT])
        begin
            if (above_umax)
                status_next = ST_RANGE;
            else
                value_next = acc;
        end
        else if (end_state.negative)
        begin
            if (above_half && !is_min_mag)
                status_next = ST_RANGE;
            else
                value_next = 64'd0 - acc;
        end
        else
        begin
            if (above_half)
                status_next = ST_RANGE;
            else
                value_next = acc;
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (end_ready)
        begin
            out_valid_reg <= end_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (end_ready && end_valid)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign value    = value_reg;
    assign status   = status_reg;

endmodule

// File: tb/sv/ascii_parse_checker.sv
`timescale 1ns / 1ps

// Watches the config, character and result channels, keeps its own parse
// state per string and compares every result beat with the oldest one owed.
module ascii_parse_checker import aip_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // last_char
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // [63:0] value
    input  logic [1:0]  m_tuser,   // [1:0] status
    output int          fail_count,
    output int          results_owed
);

    typedef struct {
        logic [63:0] value;
        status_t     status;
    } parse_result_t;

    logic [2:0]    target_type;
    str_state_t    str;
    parse_result_t owed_q[$];
    int            reported;

    function automatic int dec_digit(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) ? int'(c - CH_ZERO) : -1;
    endfunction

    function automatic int hex_digit(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c - CH_ZERO);
        if (c >= CH_UP_A && c <= CH_UP_F)
            return int'(c - CH_UP_A) + 10;
        return -1;
    endfunction

    // First character of the body, after an optional sign
    function void open_body(logic [7:0] c);
        int d;
        d = dec_digit(c);
        if (d < 0)
        begin
            str.syntax_bad = 1'b1;
        end
        else
        begin
            str.acc         = 64'(d);
            str.digit_count = 5'd1;
            str.phase       = (d == 0) ? PH_ZERO : PH_DEC;
        end
    endfunction

    // Further decimal digit; overflow past 2^64-1 is remembered in a flag while the accumulator wraps
    function void add_dec_digit(logic [7:0] c);
        int          d;
        logic [63:0] limit;
        d = dec_digit(c);
        if (d < 0 || str.digit_count >= MAX_DEC_DIGITS)
        begin
            str.syntax_bad = 1'b1;
            return;
        end
        str.digit_count = str.digit_count + 5'd1;
        limit = (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'd10;
        if (str.acc > limit)
            str.overflowed = 1'b1;
        str.acc   = str.acc * 64'd10 + 64'(d);
        str.phase = PH_DEC;
    endfunction

    function void parse_char(logic [7:0] c);
        int d;
        if (str.syntax_bad)
            return;
        case (str.phase)
            PH_START:
            begin
                if (c == CH_PLUS || c == CH_MINUS)
                begin
                    if (!target_type[TYPE_SIGNED_BIT])
                    begin
                        str.syntax_bad = 1'b1;
                    end
                    else
                    begin
                        str.negative = (c == CH_MINUS);
                        str.phase    = PH_SIGN;
                    end
                end
                else
                begin
                    open_body(c);
                end
            end
            PH_SIGN:
            begin
                open_body(c);
            end
            PH_ZERO:
            begin
                if (c == CH_LO_X || c == CH_UP_X)
                begin
                    str.digit_count = 5'd0;
                    str.acc         = 64'd0;
                    str.phase       = PH_HEXP;
                end
                else
                begin
                    add_dec_digit(c);
                end
            end
            PH_DEC:
            begin
                add_dec_digit(c);
            end
            PH_HEXP, PH_HEX:
            begin
                d = hex_digit(c);
                if (d < 0 || str.digit_count >= MAX_HEX_DIGITS)
                begin
                    str.syntax_bad = 1'b1;
                end
                else
                begin
                    str.digit_count = str.digit_count + 5'd1;
                    str.acc         = (str.acc << 4) | 64'(d);
                    str.phase       = PH_HEX;
                end
            end
            default:
            begin
                str.syntax_bad = 1'b1;
            end
        endcase
    endfunction

    // Range check against the type in force at the final character
    function parse_result_t close_string();
        parse_result_t r;
        logic [63:0]   umax;
        r.value  = 64'd0;
        r.status = ST_OK;
        umax = (target_type[1:0] == SIZE_64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                             : (64'd1 << (8 << target_type[1:0])) - 64'd1;
        if (str.syntax_bad ||
            !(str.phase == PH_ZERO || str.phase == PH_DEC || str.phase == PH_HEX))
            r.status = ST_SYNTAX;
        else if (str.overflowed)
            r.status = ST_RANGE;
        else if (!target_type[TYPE_SIGNED_BIT])
        begin
            if (str.acc > umax)
                r.status = ST_RANGE;
            else
                r.value = str.acc;
        end
        else if (str.negative)
        begin
            if (str.acc > (umax >> 1) + 64'd1)
                r.status = ST_RANGE;
            else
                r.value = 64'd0 - str.acc;
        end
        else
        begin
            if (str.acc > (umax >> 1))
                r.status = ST_RANGE;
            else
                r.value = str.acc;
        end
        return r;
    endfunction

    function void flag_mismatch(string msg);
        fail_count++;
        if (reported < 10)
        begin
            $display("%0t: %s", $realtime, msg);
            reported++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        parse_result_t want;
        if (!rst_n)
        begin
            target_type = TYPE_RESET;
            str         = STR_CLEAR;
            fail_count  = 0;
            reported    = 0;
            owed_q.delete();
            results_owed <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                target_type = cfg_data;

            // Result beat against the oldest owed result
            if (m_tvalid && m_tready)
            begin
                if (owed_q.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result beat: value %h status %0d",
                                            m_tdata, m_tuser));
                end
                else
                begin
                    want = owed_q.pop_front();
                    if (m_tdata !== want.value || m_tuser !== want.status)
                        flag_mismatch($sformatf(
                            "result mismatch: expected value %h status %0d, got value %h status %0d",
                            want.value, want.status, m_tdata, m_tuser));
                end
            end

            // Character beat
            if (s_tvalid && s_tready)
            begin
                parse_char(s_tdata);
                if (s_tlast)
                begin
                    owed_q.push_back(close_string());
                    str = STR_CLEAR;
                end
            end
            results_owed <= owed_q.size();
        end
    end

endmodule

// File: tb/sv/tb_ascii_integer_parser.sv
`timescale 1ns / 1ps

module tb_ascii_integer_parser;
    import aip_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int STALL_LIMIT  = 2000;  // cycles with no beat on any channel
    localparam int RANDOM_CHARS = 600;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_data  = TYPE_RESET;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tready  = 1'b0;
    wire         cfg_ready;
    wire         s_tready;
    wire         m_tvalid;
    wire  [63:0] m_tdata;
    wire  [1:0]  m_tuser;

    int          fail_count;
    int          results_owed;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          quiet_cycles   = 0;
    int          chars_sent     = 0;
    logic [2:0]  cur_type       = TYPE_RESET;
    logic [7:0]  text[$];

    ascii_integer_parser u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    ascii_parse_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result side back-pressure
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Watchdog on cycles with no beat anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        chars_sent++;
    endtask

    task send_text();
        foreach (text[i])
            send_char(text[i], i == text.size() - 1);
    endtask

    task send_literal(input string s);
        text.delete();
        for (int i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        send_text();
    endtask

    // Stop sending, let every owed result drain, then let the pipe settle
    task wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (results_owed != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task set_target_type(input logic [2:0] t);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= t;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_type = t;
    endtask

    task push_hex_digits(input logic [63:0] v, input int ndig);
        logic [3:0] nib;
        for (int i = ndig - 1; i >= 0; i--)
        begin
            nib = (i >= 16) ? 4'd0 : v[4*i +: 4];
            text.push_back((nib < 10) ? CH_ZERO + 8'(nib) : CH_UP_A + 8'(nib) - 8'd10);
        end
    endtask

    // One random string: mostly well formed with random content, some
    // corrupted, some pure noise
    task build_random_string();
        int          kind;
        int          n;
        int          idx;
        logic [63:0] umax;
        logic [63:0] v;
        string       digits;
        string       lower_chars;
        lower_chars = "abcdefx";
        text.delete();
        kind = $urandom_range(0, 99);
        if (kind >= 85)
        begin
            n = $urandom_range(1, 6);
            repeat (n)
                text.push_back(8'($urandom_range(0, 255)));
            return;
        end

        // optional sign, rarely on unsigned types
        if ($urandom_range(0, 99) < (cur_type[TYPE_SIGNED_BIT] ? 65 : 5))
            text.push_back(($urandom_range(0, 2) == 0) ? CH_PLUS : CH_MINUS);

        // magnitude near the type's limits or random
        umax = (cur_type[1:0] == SIZE_64) ? 64'hFFFF_FFFF_FFFF_FFFF
                                          : (64'd1 << (8 << cur_type[1:0])) - 64'd1;
        case ($urandom_range(0, 5))
            0: v = umax + 64'($urandom_range(0, 4)) - 64'd2;
            1: v = (umax >> 1) + 64'($urandom_range(0, 4)) - 64'd1;
            2: v = 64'($urandom_range(0, 300));
            3: v = {$urandom, $urandom} >> $urandom_range(0, 63);
            4: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            default: v = {$urandom, $urandom};
        endcase

        if ($urandom_range(0, 2) == 0)
        begin
            text.push_back(CH_ZERO);
            text.push_back($urandom_range(0, 1) ? CH_UP_X : CH_LO_X);
            n = 1;
            while (n < 16 && (v >> (4 * n)) != 64'd0)
                n++;
            if ($urandom_range(0, 4) == 0)
                n += $urandom_range(0, 2);
            push_hex_digits(v, n);
        end
        else
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    n = $urandom_range(1, 21);
                    repeat (n)
                        text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                2:
                begin
                    digits = "1844674407370955161";
                    for (int i = 0; i < digits.len(); i++)
                        text.push_back(digits[i]);
                    text.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                default:
                begin
                    if ($urandom_range(0, 4) == 0)
                        repeat ($urandom_range(1, 2))
                            text.push_back(CH_ZERO);
                    digits = $sformatf("%0d", v);
                    for (int i = 0; i < digits.len(); i++)
                        text.push_back(digits[i]);
                end
            endcase
        end

        // broken variants of a well-formed string
        if (kind >= 60)
        begin
            idx = $urandom_range(0, text.size() - 1);
            case ($urandom_range(0, 2))
                0: text[idx] = 8'($urandom_range(0, 255));
                1: text = text[0:idx];
                default: text[idx] = lower_chars[$urandom_range(0, 6)];
            endcase
        end
    endtask

    initial
    begin
        int strings_done;
        int random_goal;
        strings_done = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset type is u64
        send_literal("0");
        send_literal("18446744073709551615");
        send_literal("18446744073709551616");
        send_literal("0xFFFFFFFFFFFFFFFF");
        send_literal("0X00000000000000001");
        send_literal("000000000000000000007");
        send_literal("99999999999999999999q");
        send_literal("0xab");
        send_literal("+7");
        send_literal("0x");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);

        set_target_type(3'd4);
        send_literal("-128");
        send_literal("-129");
        send_literal("127");
        send_literal("128");
        send_literal("-0");
        send_literal("-");
        send_literal("+0x7F");
        send_literal("-0x81");

        set_target_type(3'd0);
        send_literal("255");
        send_literal("256");

        set_target_type(3'd7);
        send_literal("-9223372036854775808");
        send_literal("9223372036854775808");

        // sign taken under s64, range checked under u8
        send_char(CH_MINUS, 1'b0);
        set_target_type(3'd0);
        send_char(CH_ZERO + 8'd5, 1'b1);

        // Random strings over four idling phases
        random_goal = chars_sent;
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 71; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 71; end
                default: begin src_idle_pct = 12; sink_stall_pct = 12; end
            endcase
            random_goal += RANDOM_CHARS / 4;
            while (chars_sent < random_goal)
            begin
                if (strings_done % 12 == 0)
                    set_target_type(3'($urandom_range(0, 7)));
                build_random_string();
                send_text();
                strings_done++;
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
